>>> hdl/irr_pkg.sv
`timescale 1ns / 1ps

package irr_pkg;

  localparam int ADDR_W  = 16;
  localparam int LINK_W  = 3;
  localparam int ASKER_W = 4;
  localparam int CNT_W   = 4;
  localparam int PORT_W  = 2;
  localparam int ENTRY_W = ASKER_W + ADDR_W;

  localparam logic [CNT_W-1:0] OPEN_COUNT_MAX     = 4'd15;
  localparam logic [CNT_W-1:0] SWITCH_COUNT_RESET = 4'd1;

  localparam logic CMD_OPEN  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_ADD = 1'b1;

  localparam logic [PORT_W-1:0] PORT_DROP  = 2'd0;
  localparam logic [PORT_W-1:0] PORT_LOWER = 2'd1;
  localparam logic [PORT_W-1:0] PORT_UPPER = 2'd2;

  typedef struct packed {
    logic              we;
    logic [LINK_W-1:0] link;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
  } table_wr_t;

endpackage

>>> hdl/irr_range_table.sv
`timescale 1ns / 1ps

module irr_range_table #(
  parameter int DEPTH = 8,
  parameter int IW    = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  irr_pkg::table_wr_t         wr,
  input  logic                       rd_en,
  input  logic [IW-1:0]              rd_addr,
  output logic [irr_pkg::ADDR_W-1:0] rd_lo,
  output logic [irr_pkg::ADDR_W-1:0] rd_hi
);

  logic [2*irr_pkg::ADDR_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]             valid;
  logic [2*irr_pkg::ADDR_W-1:0] rd_data;
  logic                         rd_valid;
  logic                         wr_in_range;
  logic [IW-1:0]                wr_addr;

  assign wr_in_range = (32'(wr.link) < DEPTH);
  assign wr_addr     = IW'(wr.link);

  always_ff @(posedge clk) begin
    if (wr.we && wr_in_range) begin
      mem[wr_addr] <= {wr.lo, wr.hi};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.we && wr_in_range) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_lo = rd_valid ? rd_data[2*irr_pkg::ADDR_W-1:irr_pkg::ADDR_W] : '0;
  assign rd_hi = rd_valid ? rd_data[irr_pkg::ADDR_W-1:0] : '0;

endmodule

>>> hdl/ip_range_route_resolver.sv
`timescale 1ns / 1ps

// Channel   Signals                                              Handshake
// input     command link range_start range_end asker dest_ip     start & !busy
// result    kind reply_link rule_low rule_high forward out_port  result_valid, 1 cycle
//           last
// config    switch_count                                         switch_count_we
//
// An open is accepted from idle; its ACK appears the cycle after acceptance.
// An answered query keeps busy high while it reads n = min(switch_count, MAX_SWITCHES)
// range table entries, one range table read per cycle, and emits its result (no reads
// when n is zero); each drained backlog query first passes S_BL_RD and S_BL_LD.
// A queued query gives no result.
// Synchronous reset clears the table valid bits, open counter and backlog pointers, and sets switch_count to one.
// The receiver cannot stall: each result is on the ports for exactly one cycle.

module ip_range_route_resolver #(
  parameter int MAX_SWITCHES  = 8,
  parameter int BACKLOG_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic [irr_pkg::LINK_W-1:0]  link,
  input  logic [irr_pkg::ADDR_W-1:0]  range_start,
  input  logic [irr_pkg::ADDR_W-1:0]  range_end,
  input  logic [irr_pkg::ASKER_W-1:0] asker,
  input  logic [irr_pkg::ADDR_W-1:0]  dest_ip,
  input  logic                        switch_count_we,
  input  logic [irr_pkg::CNT_W-1:0]   switch_count,
  output logic                        result_valid,
  output logic                        kind,
  output logic [irr_pkg::LINK_W-1:0]  reply_link,
  output logic [irr_pkg::ADDR_W-1:0]  rule_low,
  output logic [irr_pkg::ADDR_W-1:0]  rule_high,
  output logic                        forward,
  output logic [irr_pkg::PORT_W-1:0]  out_port,
  output logic                        last
);

  localparam int IW = (MAX_SWITCHES > 1) ? $clog2(MAX_SWITCHES) : 1;
  localparam int AW = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
  localparam int FW = $clog2(BACKLOG_DEPTH + 1);
  localparam logic [4:0]  MAX_N      = 5'(MAX_SWITCHES);
  localparam logic [FW:0] DEPTH_S    = (FW+1)'(BACKLOG_DEPTH);
  localparam logic [FW-1:0] FILL_FULL = FW'(BACKLOG_DEPTH);
  localparam logic [AW-1:0] HEAD_LAST = AW'(BACKLOG_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BL_RD = 3'd1;
  localparam logic [2:0] S_BL_LD = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]                  state;
  logic [irr_pkg::CNT_W-1:0]   sw_count;
  logic [irr_pkg::CNT_W-1:0]   open_count;
  logic [irr_pkg::CNT_W-1:0]   open_count_next;
  logic [AW-1:0]               head;
  logic [FW-1:0]               fill;
  logic                        draining;
  logic [irr_pkg::ASKER_W-1:0] q_asker;
  logic [irr_pkg::ADDR_W-1:0]  q_dest;
  logic [4:0]                  rd_idx;
  logic                        cmp_valid;
  logic [4:0]                  cmp_idx;
  logic                        hit;
  logic [4:0]                  win_idx;
  logic [irr_pkg::ADDR_W-1:0]  win_lo;
  logic [irr_pkg::ADDR_W-1:0]  win_hi;

  logic [irr_pkg::ENTRY_W-1:0] bl_mem [BACKLOG_DEPTH];
  logic [irr_pkg::ENTRY_W-1:0] bl_rdata;
  logic                        bl_we;
  logic [FW:0]                 pos_sum;
  logic [FW:0]                 pos_wrap;
  logic [AW-1:0]               bl_waddr;

  irr_pkg::table_wr_t          tbl_wr;
  logic                        tbl_rd_en;
  logic [irr_pkg::ADDR_W-1:0]  t_lo;
  logic [irr_pkg::ADDR_W-1:0]  t_hi;

  logic                        accept;
  logic [4:0]                  n_entries;
  logic                        cur_hit;
  logic                        scan_last;
  logic                        open_drain;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign n_entries = ({1'b0, sw_count} > MAX_N) ? MAX_N : {1'b0, sw_count};

  assign open_count_next = (open_count == irr_pkg::OPEN_COUNT_MAX) ?
                           open_count : open_count + 4'd1;
  assign open_drain = (open_count_next == sw_count) && (fill != '0);

  assign tbl_wr.we   = accept && (command == irr_pkg::CMD_OPEN);
  assign tbl_wr.link = link;
  assign tbl_wr.lo   = range_start;
  assign tbl_wr.hi   = range_end;
  assign tbl_rd_en   = (state == S_SCAN) && (rd_idx < n_entries);

  assign cur_hit   = cmp_valid && (q_dest >= t_lo) && (q_dest <= t_hi);
  assign scan_last = cmp_valid && (cmp_idx == n_entries - 5'd1);

  assign pos_sum  = (FW+1)'(head) + (FW+1)'(fill);
  assign pos_wrap = (pos_sum >= DEPTH_S) ? pos_sum - DEPTH_S : pos_sum;
  assign bl_waddr = AW'(pos_wrap);
  assign bl_we    = accept && (command == irr_pkg::CMD_QUERY) &&
                    (open_count < sw_count) && (fill != FILL_FULL);

  irr_range_table #(
    .DEPTH(MAX_SWITCHES),
    .IW   (IW)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .wr     (tbl_wr),
    .rd_en  (tbl_rd_en),
    .rd_addr(rd_idx[IW-1:0]),
    .rd_lo  (t_lo),
    .rd_hi  (t_hi)
  );

  always_ff @(posedge clk) begin
    if (bl_we) begin
      bl_mem[bl_waddr] <= {asker, dest_ip};
    end
    if (state == S_BL_RD) begin
      bl_rdata <= bl_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sw_count     <= irr_pkg::SWITCH_COUNT_RESET;
      open_count   <= '0;
      head         <= '0;
      fill         <= '0;
      draining     <= 1'b0;
      cmp_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (switch_count_we) begin
        sw_count <= switch_count;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (command == irr_pkg::CMD_OPEN)) begin
            open_count   <= open_count_next;
            result_valid <= 1'b1;
            kind         <= irr_pkg::KIND_ACK;
            reply_link   <= link;
            rule_low     <= '0;
            rule_high    <= '0;
            forward      <= 1'b0;
            out_port     <= irr_pkg::PORT_DROP;
            last         <= !open_drain;
            if (open_drain) begin
              draining <= 1'b1;
              state    <= S_BL_RD;
            end
          end else if (accept) begin
            if (open_count < sw_count) begin
              if (fill != FILL_FULL) begin
                fill <= fill + FW'(1);
              end
            end else begin
              q_asker   <= asker;
              q_dest    <= dest_ip;
              rd_idx    <= '0;
              cmp_valid <= 1'b0;
              hit       <= 1'b0;
              state     <= (n_entries == '0) ? S_EMIT : S_SCAN;
            end
          end
        end
        S_BL_RD: begin
          head  <= (head == HEAD_LAST) ? '0 : head + AW'(1);
          fill  <= fill - FW'(1);
          state <= S_BL_LD;
        end
        S_BL_LD: begin
          q_asker   <= bl_rdata[irr_pkg::ENTRY_W-1:irr_pkg::ADDR_W];
          q_dest    <= bl_rdata[irr_pkg::ADDR_W-1:0];
          rd_idx    <= '0;
          cmp_valid <= 1'b0;
          hit       <= 1'b0;
          state     <= (n_entries == '0) ? S_EMIT : S_SCAN;
        end
        S_SCAN: begin
          cmp_valid <= tbl_rd_en;
          cmp_idx   <= rd_idx;
          if (tbl_rd_en) begin
            rd_idx <= rd_idx + 5'd1;
          end
          // later entries override earlier matches
          if (cur_hit) begin
            hit     <= 1'b1;
            win_idx <= cmp_idx;
            win_lo  <= t_lo;
            win_hi  <= t_hi;
          end
          if (scan_last) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          kind         <= irr_pkg::KIND_ADD;
          reply_link   <= irr_pkg::LINK_W'(q_asker - 4'd1);
          rule_low     <= hit ? win_lo : q_dest;
          rule_high    <= hit ? win_hi : q_dest;
          forward      <= hit;
          if (!hit) begin
            out_port <= irr_pkg::PORT_DROP;
          end else if ((6'(win_idx) + 6'd1) < 6'(q_asker)) begin
            out_port <= irr_pkg::PORT_LOWER;
          end else begin
            out_port <= irr_pkg::PORT_UPPER;
          end
          last <= !(draining && (fill != '0));
          if (draining && (fill != '0)) begin
            state <= S_BL_RD;
          end else begin
            draining <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/tb_ip_range_route_resolver.sv
`timescale 1ns / 1ps

module tb_ip_range_route_resolver;

  localparam int TABLE_SLOTS    = 8;
  localparam int BACKLOG_SLOTS  = 16;
  localparam int RANDOM_ITEMS   = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int CFG_HOLDOFF    = 4;

  typedef struct packed {
    logic                        command;
    logic [irr_pkg::LINK_W-1:0]  link;
    logic [irr_pkg::ADDR_W-1:0]  range_start;
    logic [irr_pkg::ADDR_W-1:0]  range_end;
    logic [irr_pkg::ASKER_W-1:0] asker;
    logic [irr_pkg::ADDR_W-1:0]  dest_ip;
  } route_req_t;

  typedef struct packed {
    logic                       kind;
    logic [irr_pkg::LINK_W-1:0] reply_link;
    logic [irr_pkg::ADDR_W-1:0] rule_low;
    logic [irr_pkg::ADDR_W-1:0] rule_high;
    logic                       forward;
    logic [irr_pkg::PORT_W-1:0] out_port;
    logic                       last;
  } route_reply_t;

  typedef struct packed {
    logic [irr_pkg::ASKER_W-1:0] asker;
    logic [irr_pkg::ADDR_W-1:0]  dest_ip;
  } held_query_t;

  typedef struct packed {
    bit                        cfg;
    logic [irr_pkg::CNT_W-1:0] cfg_value;
    route_req_t                req;
    bit                        typed;
    route_reply_t              reply;
  } plan_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        command = irr_pkg::CMD_OPEN;
  logic [irr_pkg::LINK_W-1:0]  link = '0;
  logic [irr_pkg::ADDR_W-1:0]  range_start = '0;
  logic [irr_pkg::ADDR_W-1:0]  range_end = '0;
  logic [irr_pkg::ASKER_W-1:0] asker = '0;
  logic [irr_pkg::ADDR_W-1:0]  dest_ip = '0;
  logic                        switch_count_we = 1'b0;
  logic [irr_pkg::CNT_W-1:0]   switch_count = '0;
  logic                        result_valid;
  logic                        kind;
  logic [irr_pkg::LINK_W-1:0]  reply_link;
  logic [irr_pkg::ADDR_W-1:0]  rule_low;
  logic [irr_pkg::ADDR_W-1:0]  rule_high;
  logic                        forward;
  logic [irr_pkg::PORT_W-1:0]  out_port;
  logic                        last;

  // predictor state
  logic [irr_pkg::ADDR_W-1:0] low_bound [TABLE_SLOTS];
  logic [irr_pkg::ADDR_W-1:0] high_bound [TABLE_SLOTS];
  logic [irr_pkg::CNT_W-1:0]  opened = '0;
  logic [irr_pkg::CNT_W-1:0]  target_count = irr_pkg::SWITCH_COUNT_RESET;
  held_query_t                held_queries [$];
  route_reply_t               expected_replies [$];

  int  fail_count = 0;
  int  replies_checked = 0;
  int  effective_items = 0;
  int  dropped_queries = 0;
  int  drains = 0;
  int  stalled_cycles = 0;
  bit  no_gaps = 1'b0;

  ip_range_route_resolver DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .link(link), .range_start(range_start), .range_end(range_end),
    .asker(asker), .dest_ip(dest_ip),
    .switch_count_we(switch_count_we), .switch_count(switch_count),
    .result_valid(result_valid), .kind(kind), .reply_link(reply_link),
    .rule_low(rule_low), .rule_high(rule_high), .forward(forward),
    .out_port(out_port), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic route_reply_t resolve_route(logic [irr_pkg::ASKER_W-1:0] who,
                                                 logic [irr_pkg::ADDR_W-1:0] addr);
    route_reply_t r;
    int span;
    int winner;
    bit hit;
    span = (target_count < TABLE_SLOTS) ? int'(target_count) : TABLE_SLOTS;
    hit = 1'b0;
    winner = 0;
    for (int j = 0; j < span; j++) begin
      if (addr >= low_bound[j] && addr <= high_bound[j]) begin
        hit = 1'b1;
        winner = j;
      end
    end
    r = '0;
    r.kind = irr_pkg::KIND_ADD;
    r.reply_link = irr_pkg::LINK_W'(who + 4'd7);
    if (hit) begin
      r.rule_low = low_bound[winner];
      r.rule_high = high_bound[winner];
      r.forward = 1'b1;
      r.out_port = (winner + 1 < int'(who)) ? irr_pkg::PORT_LOWER : irr_pkg::PORT_UPPER;
    end else begin
      r.rule_low = addr;
      r.rule_high = addr;
      r.out_port = irr_pkg::PORT_DROP;
    end
    return r;
  endfunction

  // returns 1 when the item is dropped on a full backlog
  function automatic bit predict_item(route_req_t req);
    route_reply_t r;
    held_query_t q;
    if (req.command == irr_pkg::CMD_OPEN) begin
      low_bound[req.link] = req.range_start;
      high_bound[req.link] = req.range_end;
      if (opened < irr_pkg::OPEN_COUNT_MAX) opened++;
      r = '0;
      r.kind = irr_pkg::KIND_ACK;
      r.reply_link = req.link;
      r.out_port = irr_pkg::PORT_DROP;
      expected_replies.push_back(r);
      if (opened == target_count && held_queries.size() != 0) begin
        drains++;
        while (held_queries.size() != 0) begin
          q = held_queries.pop_front();
          expected_replies.push_back(resolve_route(q.asker, q.dest_ip));
        end
      end
    end else if (opened < target_count) begin
      if (held_queries.size() >= BACKLOG_SLOTS) begin
        dropped_queries++;
        return 1'b1;
      end
      held_queries.push_back({req.asker, req.dest_ip});
      return 1'b0;
    end else begin
      expected_replies.push_back(resolve_route(req.asker, req.dest_ip));
    end
    expected_replies[expected_replies.size() - 1].last = 1'b1;
    return 1'b0;
  endfunction

  function automatic plan_row_t open_row(logic [irr_pkg::LINK_W-1:0] l,
                                         logic [irr_pkg::ADDR_W-1:0] lo,
                                         logic [irr_pkg::ADDR_W-1:0] hi);
    plan_row_t r;
    r = '0;
    r.req.command = irr_pkg::CMD_OPEN;
    r.req.link = l;
    r.req.range_start = lo;
    r.req.range_end = hi;
    return r;
  endfunction

  function automatic plan_row_t query_row(logic [irr_pkg::ASKER_W-1:0] a,
                                          logic [irr_pkg::ADDR_W-1:0] d);
    plan_row_t r;
    r = '0;
    r.req.command = irr_pkg::CMD_QUERY;
    r.req.asker = a;
    r.req.dest_ip = d;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [irr_pkg::CNT_W-1:0] v);
    plan_row_t r;
    r = '0;
    r.cfg = 1'b1;
    r.cfg_value = v;
    return r;
  endfunction

  function automatic plan_row_t with_reply(plan_row_t r, logic k,
                                           logic [irr_pkg::LINK_W-1:0] l,
                                           logic [irr_pkg::ADDR_W-1:0] lo,
                                           logic [irr_pkg::ADDR_W-1:0] hi,
                                           logic fwd, logic [irr_pkg::PORT_W-1:0] p);
    r.typed = 1'b1;
    r.reply = {k, l, lo, hi, fwd, p, 1'b1};
    return r;
  endfunction

  function automatic route_req_t random_request(bit is_open);
    route_req_t r;
    int slot;
    int hi_sum;
    r.command = is_open ? irr_pkg::CMD_OPEN : irr_pkg::CMD_QUERY;
    r.link = irr_pkg::LINK_W'($urandom_range(0, 7));
    r.asker = irr_pkg::ASKER_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(1, 8));
    r.dest_ip = irr_pkg::ADDR_W'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 5))
      0: begin
        r.range_start = 16'h0000;
        r.range_end = 16'hFFFF;
      end
      1: begin
        r.range_start = irr_pkg::ADDR_W'($urandom_range(1, 16'hFFFF));
        r.range_end = irr_pkg::ADDR_W'($urandom_range(0, r.range_start - 1));
      end
      2: begin
        r.range_start = irr_pkg::ADDR_W'($urandom_range(0, 16'hFFFF));
        r.range_end = r.range_start;
      end
      default: begin
        r.range_start = irr_pkg::ADDR_W'($urandom_range(0, 16'hFFFF));
        hi_sum = int'(r.range_start) + int'($urandom_range(0, 16'h3FFF));
        r.range_end = (hi_sum > 16'hFFFF) ? 16'hFFFF : irr_pkg::ADDR_W'(hi_sum);
      end
    endcase
    case ($urandom_range(0, 3))
      0: ;
      1: r.dest_ip = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: begin
        slot = $urandom_range(0, TABLE_SLOTS - 1);
        if (low_bound[slot] <= high_bound[slot])
          r.dest_ip = irr_pkg::ADDR_W'($urandom_range(low_bound[slot], high_bound[slot]));
      end
    endcase
    return r;
  endfunction

  task automatic send_item(route_req_t req, bit typed, route_reply_t typed_reply);
    int gap;
    command = req.command;
    link = req.link;
    range_start = req.range_start;
    range_end = req.range_end;
    asker = req.asker;
    dest_ip = req.dest_ip;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (!predict_item(req)) effective_items++;
    if (typed) begin
      void'(expected_replies.pop_back());
      expected_replies.push_back(typed_reply);
    end
    @(negedge clk);
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_switch_count(logic [irr_pkg::CNT_W-1:0] v);
    start = 1'b0;
    while (expected_replies.size() != 0 || busy !== 1'b0) @(negedge clk);
    // a queued query leaves no result behind
    repeat (CFG_HOLDOFF) @(negedge clk);
    switch_count = v;
    switch_count_we = 1'b1;
    @(negedge clk);
    switch_count_we = 1'b0;
    target_count = v;
  endtask

  always @(posedge clk) begin
    route_reply_t seen;
    route_reply_t want;
    if (!rst && result_valid === 1'b1) begin
      seen = {kind, reply_link, rule_low, rule_high, forward, out_port, last};
      replies_checked++;
      if (expected_replies.size() == 0) begin
        $error("unexpected result: kind %0d link %0d", seen.kind, seen.reply_link);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        if (seen.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, seen.kind);
          fail_count++;
        end
        if (seen.reply_link !== want.reply_link) begin
          $error("reply_link: expected %0d, got %0d", want.reply_link, seen.reply_link);
          fail_count++;
        end
        if (seen.rule_low !== want.rule_low) begin
          $error("rule_low: expected %h, got %h", want.rule_low, seen.rule_low);
          fail_count++;
        end
        if (seen.rule_high !== want.rule_high) begin
          $error("rule_high: expected %h, got %h", want.rule_high, seen.rule_high);
          fail_count++;
        end
        if (seen.forward !== want.forward) begin
          $error("forward: expected %0d, got %0d", want.forward, seen.forward);
          fail_count++;
        end
        if (seen.out_port !== want.out_port) begin
          $error("out_port: expected %0d, got %0d", want.out_port, seen.out_port);
          fail_count++;
        end
        if (seen.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, seen.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item or result for %0d cycles", WATCHDOG_LIMIT);
      $display("[ip_range_route_resolver] ERROR");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    int base;
    int flood;
    int bumped;
    bit first_phase;
    logic [irr_pkg::CNT_W-1:0] next_count;

    foreach (low_bound[j]) begin
      low_bound[j] = '0;
      high_bound[j] = '0;
    end

    plan = '{
      query_row(4'd1, 16'h0000),
      query_row(4'd0, 16'hFFFF),
      open_row(3'd0, 16'h0000, 16'hFFFF),
      with_reply(query_row(4'd15, 16'h1234), irr_pkg::KIND_ADD, 3'd6, 16'h0000, 16'hFFFF,
                 1'b1, irr_pkg::PORT_LOWER),
      with_reply(open_row(3'd7, 16'h8000, 16'h80FF), irr_pkg::KIND_ACK, 3'd7, 16'h0000,
                 16'h0000, 1'b0, irr_pkg::PORT_DROP),
      cfg_row(4'd4),
      query_row(4'd8, 16'h0000),
      query_row(4'd2, 16'h8001),
      query_row(4'd1, 16'h4000),
      open_row(3'd1, 16'h4000, 16'h4000),
      open_row(3'd2, 16'hFFFF, 16'h0000),
      with_reply(open_row(3'd3, 16'h0000, 16'h0000), irr_pkg::KIND_ACK, 3'd3, 16'h0000,
                 16'h0000, 1'b0, irr_pkg::PORT_DROP),
      query_row(4'd4, 16'h4000),
      cfg_row(4'd0),
      with_reply(query_row(4'd3, 16'hABCD), irr_pkg::KIND_ADD, 3'd2, 16'hABCD, 16'hABCD,
                 1'b0, irr_pkg::PORT_DROP),
      cfg_row(4'd15),
      query_row(4'd0, 16'h8050),
      cfg_row(4'd8),
      query_row(4'd9, 16'hFFFF),
      open_row(3'd4, 16'h1000, 16'h1FFF),
      open_row(3'd5, 16'hFFFF, 16'hFFFF),
      open_row(3'd6, 16'h8000, 16'hFFFF),
      query_row(4'd8, 16'h1000)
    };

    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        write_switch_count(plan[i].cfg_value);
      end else begin
        send_item(plan[i].req, plan[i].typed, plan[i].reply);
      end
    end

    // random phases: new switch count, backlog fill, then mixed opens and queries
    first_phase = 1'b1;
    base = effective_items;
    while (effective_items - base < RANDOM_ITEMS) begin
      if (opened < irr_pkg::OPEN_COUNT_MAX && $urandom_range(0, 3) != 0) begin
        bumped = int'(opened) + int'($urandom_range(1, 4));
        next_count = (bumped > 15) ? 4'd15 : irr_pkg::CNT_W'(bumped);
      end else begin
        next_count = irr_pkg::CNT_W'($urandom_range(0, 15));
      end
      write_switch_count(next_count);
      no_gaps = ($urandom_range(0, 2) == 0);
      if (first_phase) begin
        flood = $urandom_range(17, 20);
      end else begin
        flood = (opened < target_count) ? $urandom_range(0, 12) : 0;
      end
      first_phase = 1'b0;
      repeat (flood) send_item(random_request(1'b0), 1'b0, '0);
      repeat ($urandom_range(6, 20))
        send_item(random_request($urandom_range(0, 2) == 0), 1'b0, '0);
    end
    start = 1'b0;

    while (expected_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run: %0d items applied, %0d results checked, %0d backlog drains",
             effective_items, replies_checked, drains);
    $display("run: %0d queries dropped on a full backlog, final open count %0d",
             dropped_queries, opened);
    if (fail_count == 0) begin
      $display("[ip_range_route_resolver] OK");
    end else begin
      $display("[ip_range_route_resolver] ERROR");
    end
    $finish;
  end

endmodule
